>>> design/orb_pkg.sv
package orb_pkg;

    // Fixed field widths of the request and result items
    localparam int OP_W     = 1;
    localparam int FIELD_W  = 32;
    localparam int LEN_W    = 16;
    localparam int CNT_W    = 9;
    localparam int TOTAL_W  = 48;
    localparam int CNT_MAX  = 511;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 176;

    localparam logic [CNT_W-1:0]   CAP_RESET = 9'd256;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Request kinds
    localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
    } orb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } orb_status_t;

    // Advance a ring position by an offset, wrapping once at the capacity
    function automatic logic [CNT_W-1:0] ring_wrap(
        input logic [CNT_W-1:0] base,
        input logic [CNT_W-1:0] offset,
        input logic [CNT_W-1:0] cap
    );
        logic [CNT_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= {1'b0, cap}) begin
            sum = sum - {1'b0, cap};
        end
        return sum[CNT_W-1:0];
    endfunction

endpackage

>>> design/orb_ram.sv
module orb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/orb_ctrl.sv
module orb_ctrl
    import orb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  orb_status_t status,
    output orb_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.load   = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.commit = (state_reg == ST_COMMIT) && status.out_free;

    // Sequence one request: take it, read its slot, then commit the result
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_to_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_LOOKUP)
        else $error("accepted request did not move to lookup");

    a_lookup_to_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOOKUP |=> state_reg == ST_COMMIT)
        else $error("lookup not followed by commit");

endmodule

>>> design/orb_datapath.sv
module orb_datapath
    import orb_pkg::*;
#(
    parameter int MAX_SLOTS    = 256,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  orb_cmd_t           cmd,
    output orb_status_t        status,
    input  logic               cfg_wr_en,
    input  logic [CNT_W-1:0]   cfg_wr_data,
    input  logic [OP_W-1:0]    in_opcode,
    input  logic [FIELD_W-1:0] in_entry_handle,
    input  logic [LEN_W-1:0]   in_line_length,
    input  logic [CNT_W-1:0]   in_read_index,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               out_read_hit,
    output logic [FIELD_W-1:0] out_read_entry,
    output logic               out_evicted,
    output logic [FIELD_W-1:0] out_evicted_entry,
    output logic [CNT_W-1:0]   out_entries_held,
    output logic [TOTAL_W-1:0] out_lines_total,
    output logic [TOTAL_W-1:0] out_bytes_total
);

    localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [CNT_W-1:0] CAP_LIMIT =
        (MAX_SLOTS > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_SLOTS);

    // Configuration and ring state
    logic [CNT_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   oldest_reg, oldest_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [TOTAL_W-1:0] lines_reg, lines_next;
    logic [TOTAL_W-1:0] bytes_reg, bytes_next;

    // Latched request
    logic [OP_W-1:0]         op_reg;
    logic [HANDLE_WIDTH-1:0] handle_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [CNT_W-1:0]        idx_reg;

    // Result register
    logic               m_tvalid_reg;
    logic               hit_reg;
    logic [FIELD_W-1:0] entry_reg;
    logic               ev_reg;
    logic [FIELD_W-1:0] ev_entry_reg;
    logic [CNT_W-1:0]   held_out_reg;
    logic [TOTAL_W-1:0] lines_out_reg;
    logic [TOTAL_W-1:0] bytes_out_reg;

    logic [CNT_W-1:0]        cap_eff;
    logic [CNT_W-1:0]        held_c;
    logic                    is_full;
    logic                    push_ok;
    logic                    read_hit;
    logic                    evict;
    logic [ADDR_W-1:0]       raddr;
    logic [ADDR_W-1:0]       waddr;
    logic                    ram_we;
    logic [HANDLE_WIDTH-1:0] rdata;
    logic [TOTAL_W:0]        lines_sum;
    logic [TOTAL_W:0]        bytes_sum;

    // Clamp the capacity register to one and to the slot count
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (cap_reg > CAP_LIMIT) begin
            cap_eff = CAP_LIMIT;
        end else begin
            cap_eff = cap_reg;
        end
    end

    assign held_c   = (held_reg > cap_eff) ? cap_eff : held_reg;
    assign is_full  = (held_c == cap_eff);
    assign push_ok  = (op_reg == OP_PUSH) && (handle_reg != '0);
    assign read_hit = (op_reg == OP_READ) && (idx_reg < held_c);
    assign evict    = push_ok && is_full;

    // Pushes look up the oldest slot for eviction, reads the slot at their age
    assign raddr = (op_reg == OP_PUSH) ? ADDR_W'(oldest_reg)
                                       : ADDR_W'(ring_wrap(oldest_reg, idx_reg, cap_eff));

    // A full store overwrites the slot it evicts
    assign waddr  = is_full ? ADDR_W'(oldest_reg)
                            : ADDR_W'(ring_wrap(oldest_reg, held_c, cap_eff));
    assign ram_we = cmd.commit && push_ok;

    assign lines_sum = {1'b0, lines_reg} + (TOTAL_W + 1)'(1);
    assign bytes_sum = {1'b0, bytes_reg} + (TOTAL_W + 1)'(len_reg);

    // Work out the state after a push
    always_comb begin
        oldest_next = oldest_reg;
        held_next   = held_c;
        lines_next  = lines_reg;
        bytes_next  = bytes_reg;
        if (push_ok) begin
            if (is_full) begin
                oldest_next = ring_wrap(oldest_reg, CNT_W'(1), cap_eff);
            end else begin
                held_next = held_c + CNT_W'(1);
            end
            lines_next = lines_sum[TOTAL_W] ? TOTAL_MAX : lines_sum[TOTAL_W-1:0];
            bytes_next = bytes_sum[TOTAL_W] ? TOTAL_MAX : bytes_sum[TOTAL_W-1:0];
        end
    end

    orb_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (handle_reg),
        .re    (cmd.lookup),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Latch the accepted request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= in_opcode;
            handle_reg <= HANDLE_WIDTH'(in_entry_handle);
            len_reg    <= in_line_length;
            idx_reg    <= in_read_index;
        end
    end

    // Ring state: commit a request, or empty the store on a capacity write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_RESET;
            oldest_reg <= '0;
            held_reg   <= '0;
            lines_reg  <= '0;
            bytes_reg  <= '0;
        end else begin
            if (cmd.commit) begin
                lines_reg  <= lines_next;
                bytes_reg  <= bytes_next;
            end
            if (cfg_wr_en) begin
                cap_reg    <= cfg_wr_data;
                oldest_reg <= '0;
                held_reg   <= '0;
            end else if (cmd.commit) begin
                oldest_reg <= oldest_next;
                held_reg   <= held_next;
            end
        end
    end

    // Result valid: set on commit, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            hit_reg       <= read_hit;
            entry_reg     <= read_hit ? FIELD_W'(rdata) : '0;
            ev_reg        <= evict;
            ev_entry_reg  <= evict ? FIELD_W'(rdata) : '0;
            held_out_reg  <= held_next;
            lines_out_reg <= lines_next;
            bytes_out_reg <= bytes_next;
        end
    end

    assign status.out_free   = !m_tvalid_reg || m_tready;
    assign m_tvalid          = m_tvalid_reg;
    assign out_read_hit      = hit_reg;
    assign out_read_entry    = entry_reg;
    assign out_evicted       = ev_reg;
    assign out_evicted_entry = ev_entry_reg;
    assign out_entries_held  = held_out_reg;
    assign out_lines_total   = lines_out_reg;
    assign out_bytes_total   = bytes_out_reg;

    a_held_in_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= cap_eff)
        else $error("held count beyond effective capacity");

    a_cfg_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> held_reg == '0 && oldest_reg == '0)
        else $error("capacity write did not empty the store");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !m_tvalid_reg || m_tready)
        else $error("result overwritten before it was taken");

endmodule

>>> design/overwriting_ring_buffer.sv
// Channel  | Dir | Ports                           | Contents
// s_       | in  | s_tvalid s_tready s_tdata s_tuser | push or read request
// m_       | out | m_tvalid m_tready m_tdata        | result, one per request
// cfg_     | in  | cfg_wr_en cfg_wr_data           | capacity in use
//
// A request passes through three steps: accept, slot read from the RAM, commit.
// The registered RAM read needs its own step; a full result register holds
// the commit until the result is taken.
// Reset clears the ring pointers and totals; slot contents are not cleared.
// A new request is taken once the previous one has committed, even while
// its result still waits on m_tready.
module overwriting_ring_buffer
    import orb_pkg::*;
#(
    parameter int MAX_SLOTS    = 256,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    // Request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_handle [31:0], line_length [47:32], read_index [56:48], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode [0]
    input  logic [OP_W-1:0]      s_tuser,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_hit [0], read_entry [32:1], evicted [33], evicted_entry [65:34],
    // entries_held [74:66], lines_total [122:75], bytes_total [170:123], zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    orb_cmd_t    cmd;
    orb_status_t status;

    logic               read_hit;
    logic [FIELD_W-1:0] read_entry;
    logic               evicted;
    logic [FIELD_W-1:0] evicted_entry;
    logic [CNT_W-1:0]   entries_held;
    logic [TOTAL_W-1:0] lines_total;
    logic [TOTAL_W-1:0] bytes_total;

    orb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    orb_datapath #(
        .MAX_SLOTS    (MAX_SLOTS),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_opcode         (s_tuser),
        .in_entry_handle   (s_tdata[31:0]),
        .in_line_length    (s_tdata[47:32]),
        .in_read_index     (s_tdata[56:48]),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .out_read_hit      (read_hit),
        .out_read_entry    (read_entry),
        .out_evicted       (evicted),
        .out_evicted_entry (evicted_entry),
        .out_entries_held  (entries_held),
        .out_lines_total   (lines_total),
        .out_bytes_total   (bytes_total)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {5'd0, bytes_total, lines_total, entries_held,
                      evicted_entry, evicted, read_entry, read_hit};

endmodule

>>> tb/ring_buffer_checker.sv
`timescale 1ns / 100ps

module ring_buffer_checker
    import orb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   pending,
    output int                   fail_count
);

    localparam int SLOTS = 256;

    // Request fields as packed in s_tdata, highest field first
    typedef struct packed {
        logic [CNT_W-1:0]   read_index;
        logic [LEN_W-1:0]   line_length;
        logic [FIELD_W-1:0] entry_handle;
    } ring_request_t;

    // Result fields as packed in m_tdata, highest field first
    typedef struct packed {
        logic [TOTAL_W-1:0] bytes_total;
        logic [TOTAL_W-1:0] lines_total;
        logic [CNT_W-1:0]   entries_held;
        logic [FIELD_W-1:0] evicted_entry;
        logic               evicted;
        logic [FIELD_W-1:0] read_entry;
        logic               read_hit;
    } ring_result_t;

    // Mirror of the ring state
    logic [FIELD_W-1:0] slot_handle [SLOTS];
    int                 oldest_pos;
    int                 held_now;
    logic [CNT_W-1:0]   cap_reg;
    logic [TOTAL_W-1:0] lines_sum;
    logic [TOTAL_W-1:0] bytes_sum;
    ring_result_t       due_results [$];

    function automatic int eff_capacity();
        if (cap_reg == 0) begin
            return 1;
        end
        if (cap_reg > SLOTS) begin
            return SLOTS;
        end
        return int'(cap_reg);
    endfunction

    // Map an age onto a slot, wrapping once at the capacity
    function automatic int slot_pos(int age, int cap);
        int pos;
        pos = oldest_pos + age;
        if (pos >= cap) begin
            pos -= cap;
        end
        if (pos >= SLOTS) begin
            pos = 0;
        end
        return pos;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_add(
        logic [TOTAL_W-1:0] a,
        logic [TOTAL_W-1:0] b
    );
        logic [TOTAL_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    endfunction

    // Apply one request to the mirror and return the result it should give
    function automatic ring_result_t apply_request(
        logic [OP_W-1:0] op,
        ring_request_t   req
    );
        ring_result_t res;
        int           cap;
        res = '0;
        cap = eff_capacity();
        if (held_now > cap) begin
            held_now = cap;
        end
        if (op == OP_PUSH) begin
            if (req.entry_handle != 0) begin
                // Drop the oldest entry when full
                if (held_now == cap) begin
                    res.evicted       = 1'b1;
                    res.evicted_entry = slot_handle[slot_pos(0, cap)];
                    oldest_pos        = slot_pos(1, cap);
                    held_now--;
                end
                slot_handle[slot_pos(held_now, cap)] = req.entry_handle;
                held_now++;
                lines_sum = sat_add(lines_sum, TOTAL_W'(1));
                bytes_sum = sat_add(bytes_sum, TOTAL_W'(req.line_length));
            end
        end else if (int'(req.read_index) < held_now) begin
            res.read_hit   = 1'b1;
            res.read_entry = slot_handle[slot_pos(int'(req.read_index), cap)];
        end
        res.entries_held = CNT_W'(held_now);
        res.lines_total  = lines_sum;
        res.bytes_total  = bytes_sum;
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare results, follow capacity writes, predict accepted requests
    always @(posedge aclk) begin
        ring_result_t want;
        ring_result_t got;
        if (!aresetn) begin
            oldest_pos = 0;
            held_now   = 0;
            cap_reg    = CAP_RESET;
            lines_sum  = '0;
            bytes_sum  = '0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = ring_result_t'(m_tdata[$bits(ring_result_t)-1:0]);
                if (due_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("read_hit", want.read_hit, got.read_hit);
                    check_field("read_entry", want.read_entry, got.read_entry);
                    check_field("evicted", want.evicted, got.evicted);
                    check_field("evicted_entry", want.evicted_entry, got.evicted_entry);
                    check_field("entries_held", want.entries_held, got.entries_held);
                    check_field("lines_total", want.lines_total, got.lines_total);
                    check_field("bytes_total", want.bytes_total, got.bytes_total);
                end
            end
            // A capacity write empties the ring but keeps the totals
            if (cfg_wr_en) begin
                cap_reg    = cfg_wr_data;
                oldest_pos = 0;
                held_now   = 0;
            end
            if (s_tvalid && s_tready) begin
                due_results.push_back(apply_request(s_tuser,
                    ring_request_t'(s_tdata[$bits(ring_request_t)-1:0])));
            end
        end
        pending = due_results.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import orb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CNT_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int pending_count;
    int failures;
    int cycles = 0;
    int cap_now = 256;
    bit gaps_on;

    always #4 aclk = ~aclk;

    overwriting_ring_buffer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    ring_buffer_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .pending     (pending_count),
        .fail_count  (failures)
    );

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("overwriting_ring_buffer test failed");
            $finish;
        end
    end

    // Stall the result side in random bursts
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (gaps_on && $urandom_range(0, 9) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offer one request and hold it until taken; called and returns at a falling edge
    task automatic send_request(
        logic [OP_W-1:0]    op,
        logic [FIELD_W-1:0] handle,
        logic [LEN_W-1:0]   len,
        logic [CNT_W-1:0]   idx
    );
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = {{(S_TDATA_W - CNT_W - LEN_W - FIELD_W){1'b0}}, idx, len, handle};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Drain all outstanding requests, then write the capacity
    task automatic set_capacity(logic [CNT_W-1:0] value);
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        cap_now = (value == 0) ? 1 : ((value > 256) ? 256 : int'(value));
    endtask

    // Mixed pushes and reads at one capacity; reads mostly land near the held range
    task automatic random_phase(logic [CNT_W-1:0] cap, int count, int push_pct, bit gaps);
        logic [FIELD_W-1:0] handle;
        logic [LEN_W-1:0]   len;
        logic [CNT_W-1:0]   idx;
        set_capacity(cap);
        gaps_on = gaps;
        repeat (count) begin
            case ($urandom_range(0, 15))
                0:       handle = '0;
                1:       handle = '1;
                default: handle = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       len = '1;
                default: len = LEN_W'($urandom_range(0, 65535));
            endcase
            if ($urandom_range(0, 99) < push_pct) begin
                send_request(OP_PUSH, handle, len, CNT_W'($urandom_range(0, 511)));
            end else begin
                idx = ($urandom_range(0, 3) != 0) ? CNT_W'($urandom_range(0, cap_now + 1))
                                                  : CNT_W'($urandom_range(0, 511));
                send_request(OP_READ, handle, len, idx);
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_PUSH;
        gaps_on     = 1'b1;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Empty ring at reset capacity: miss, ignored zero handle, field extremes
        send_request(OP_READ, $urandom, LEN_W'($urandom), 9'd0);
        send_request(OP_PUSH, 32'h0, 16'hFFFF, 9'd0);
        send_request(OP_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 9'd511);
        send_request(OP_PUSH, 32'h1, 16'h0, 9'd0);
        send_request(OP_READ, $urandom, LEN_W'($urandom), 9'd0);
        send_request(OP_READ, $urandom, LEN_W'($urandom), 9'd1);
        send_request(OP_READ, $urandom, LEN_W'($urandom), 9'd2);
        send_request(OP_READ, 32'hFFFF_FFFF, 16'hFFFF, 9'd511);

        // Two slots: evict twice, then a zero handle on a full ring
        set_capacity(9'd2);
        send_request(OP_PUSH, 32'hA5A5_0001, 16'd10, CNT_W'($urandom));
        send_request(OP_PUSH, 32'h5A5A_0002, 16'd20, CNT_W'($urandom));
        send_request(OP_PUSH, 32'hA5A5_0003, 16'd30, CNT_W'($urandom));
        send_request(OP_PUSH, 32'h5A5A_0004, 16'd40, CNT_W'($urandom));
        send_request(OP_PUSH, 32'h0, 16'd50, CNT_W'($urandom));
        send_request(OP_READ, $urandom, LEN_W'($urandom), 9'd0);
        send_request(OP_READ, $urandom, LEN_W'($urandom), 9'd1);
        send_request(OP_READ, $urandom, LEN_W'($urandom), 9'd2);

        // Zero capacity acts as one slot
        set_capacity(9'd0);
        send_request(OP_PUSH, 32'h1234_5678, 16'd1, CNT_W'($urandom));
        send_request(OP_PUSH, 32'h8765_4321, 16'd2, CNT_W'($urandom));
        send_request(OP_READ, $urandom, LEN_W'($urandom), 9'd0);
        send_request(OP_READ, $urandom, LEN_W'($urandom), 9'd1);

        // Random phases; the full-size ring is filled past eviction once
        random_phase(9'd3, 60, 60, 1'b1);
        random_phase(9'd1, 40, 55, 1'b1);
        random_phase(9'd511, 320, 92, 1'b1);
        random_phase(CNT_W'($urandom_range(2, 40)), 80, 60, 1'b0);
        random_phase(9'd256, 40, 60, 1'b1);
        random_phase(CNT_W'($urandom_range(257, 510)), 30, 60, 1'b1);
        random_phase(9'd5, 60, 60, 1'b0);

        // Drain and give the verdict
        s_tvalid = 1'b0;
        gaps_on  = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (failures == 0 && pending_count == 0) begin
            $display("overwriting_ring_buffer test passed");
        end else begin
            $display("overwriting_ring_buffer test failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/orb_pkg.sv
design/orb_ram.sv
design/orb_ctrl.sv
design/orb_datapath.sv
design/overwriting_ring_buffer.sv
tb/ring_buffer_checker.sv
tb/tb_top.sv
